// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define CHK_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// property checked on every rising edge, reset included
`define CHK_PROP_ALL(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/tmph_pkg.sv -----
// constants and control types of the triple modulus polynomial hash
`timescale 1ns / 1ps
package tmph_pkg;

    localparam int SYMBOL_W            = 16;
    localparam int SYMBOL_BITS_DEFAULT = 16;

    localparam logic [63:0] HASH_BASE = 64'd1777771;

    localparam int HASH_A_BITS = 30;
    localparam int HASH_B_BITS = 30;
    localparam int HASH_C_BITS = 27;

    localparam logic [63:0] MOD_A = 64'd1000000007;
    localparam logic [63:0] MOD_B = 64'd1000000009;
    localparam logic [63:0] MOD_C = 64'd100000007;

    // barrett reciprocals floor(2^(2k) / m)
    localparam logic [63:0] MU_A = (64'd1 << (2 * HASH_A_BITS)) / MOD_A;
    localparam logic [63:0] MU_B = (64'd1 << (2 * HASH_B_BITS)) / MOD_B;
    localparam logic [63:0] MU_C = (64'd1 << (2 * HASH_C_BITS)) / MOD_C;

    // base^1, base^2 and base^3 reduced per modulus
    localparam logic [63:0] POW1_A = HASH_BASE % MOD_A;
    localparam logic [63:0] POW1_B = HASH_BASE % MOD_B;
    localparam logic [63:0] POW1_C = HASH_BASE % MOD_C;
    localparam logic [63:0] POW2_A = (POW1_A * POW1_A) % MOD_A;
    localparam logic [63:0] POW2_B = (POW1_B * POW1_B) % MOD_B;
    localparam logic [63:0] POW2_C = (POW1_C * POW1_C) % MOD_C;
    localparam logic [63:0] POW3_A = (POW2_A * POW1_A) % MOD_A;
    localparam logic [63:0] POW3_B = (POW2_B * POW1_B) % MOD_B;
    localparam logic [63:0] POW3_C = (POW2_C * POW1_C) % MOD_C;

    typedef struct packed {
        logic take;     // input transaction accepted
        logic restart;  // accepted transaction closes its sequence
        logic ld_mul;   // product stage loads
        logic ld_quo;   // quotient stage loads
        logic ld_fold;  // fold stage loads
        logic commit;   // item moves into the output register
        logic clear;    // committed item closes its sequence
    } tmph_ctl_t;

endpackage

// ----- hw/rtl/tmph_pow_ring.sv -----
// power generator: base^i mod m from a three stage look-ahead ring
`timescale 1ns / 1ps
module tmph_pow_ring #(
    parameter int          HASH_BITS = tmph_pkg::HASH_A_BITS,
    parameter logic [63:0] MODULUS   = tmph_pkg::MOD_A,
    parameter logic [63:0] MU        = tmph_pkg::MU_A,
    parameter logic [63:0] STEP      = tmph_pkg::POW3_A,
    parameter logic [63:0] SEED1     = tmph_pkg::POW1_A,
    parameter logic [63:0] SEED2     = tmph_pkg::POW2_A
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  tmph_pkg::tmph_ctl_t    ctl,
    output logic [HASH_BITS-1:0]   power
);
    import tmph_pkg::*;

    localparam int K  = HASH_BITS;
    localparam int XW = 2 * K;
    localparam int QW = K + 1;
    localparam int RW = K + 2;

    // ring: cur holds base^i, fold holds base^(i+1) in flight,
    // mul holds base^(i+2) in flight
    logic [K-1:0]    cur_reg;
    logic [XW-1:0]   mul_reg;
    logic [RW-1:0]   fold_x_reg;
    logic [QW-1:0]   fold_q_reg;

    logic [XW-1:0]   mul_next;
    logic [2*QW-1:0] quo_prod;
    logic [QW-1:0]   quo_q;
    logic [RW-1:0]   fold_qm;
    logic [RW-1:0]   fold_r0;
    logic [RW-1:0]   fold_r1;
    logic [RW-1:0]   fold_r2;

    assign mul_next = {{K{1'b0}}, cur_reg} * {{K{1'b0}}, STEP[K-1:0]};

    assign quo_prod = {{QW{1'b0}}, mul_reg[XW-1:K-1]} * {{QW{1'b0}}, MU[QW-1:0]};
    assign quo_q    = quo_prod[2*QW-1:K+1];

    assign fold_qm = {1'b0, fold_q_reg} * MODULUS[RW-1:0];
    assign fold_r0 = fold_x_reg - fold_qm;
    assign fold_r1 = (fold_r0 >= MODULUS[RW-1:0]) ? fold_r0 - MODULUS[RW-1:0] : fold_r0;
    assign fold_r2 = (fold_r1 >= MODULUS[RW-1:0]) ? fold_r1 - MODULUS[RW-1:0] : fold_r1;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.restart) begin
            cur_reg    <= K'(1);
            mul_reg    <= SEED2[XW-1:0];
            fold_x_reg <= SEED1[RW-1:0];
            fold_q_reg <= '0;
        end else if (ctl.take) begin
            cur_reg    <= fold_r2[K-1:0];
            mul_reg    <= mul_next;
            fold_x_reg <= mul_reg[RW-1:0];
            fold_q_reg <= quo_q;
        end
    end

    assign power = cur_reg;

endmodule

// ----- hw/rtl/tmph_lane.sv -----
// one modulus lane: term pipeline, barrett reduction and accumulator
`timescale 1ns / 1ps
module tmph_lane #(
    parameter int          HASH_BITS = tmph_pkg::HASH_A_BITS,
    parameter int          SYM_BITS  = tmph_pkg::SYMBOL_BITS_DEFAULT,
    parameter logic [63:0] MODULUS   = tmph_pkg::MOD_A,
    parameter logic [63:0] MU        = tmph_pkg::MU_A,
    parameter logic [63:0] STEP      = tmph_pkg::POW3_A,
    parameter logic [63:0] SEED1     = tmph_pkg::POW1_A,
    parameter logic [63:0] SEED2     = tmph_pkg::POW2_A
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  tmph_pkg::tmph_ctl_t    ctl,
    input  logic [SYM_BITS-1:0]    sym,
    output logic [HASH_BITS-1:0]   hash
);
    import tmph_pkg::*;

    localparam int K  = HASH_BITS;
    localparam int XW = 2 * K;
    localparam int QW = K + 1;
    localparam int RW = K + 2;

    logic [K-1:0]    power;

    logic [XW-1:0]   mul_reg;
    logic [RW-1:0]   quo_x_reg;
    logic [QW-1:0]   quo_q_reg;
    logic [K-1:0]    term_reg;
    logic [K-1:0]    acc_reg;
    logic [K-1:0]    hash_reg;

    logic [XW-1:0]   mul_next;
    logic [2*QW-1:0] quo_prod;
    logic [QW-1:0]   quo_q;
    logic [RW-1:0]   fold_qm;
    logic [RW-1:0]   fold_r0;
    logic [RW-1:0]   fold_r1;
    logic [RW-1:0]   fold_r2;
    logic [K:0]      sum_raw;
    logic [K:0]      sum_mod;

    tmph_pow_ring #(
        .HASH_BITS (HASH_BITS),
        .MODULUS   (MODULUS),
        .MU        (MU),
        .STEP      (STEP),
        .SEED1     (SEED1),
        .SEED2     (SEED2)
    ) u_pow_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .power   (power)
    );

    // symbol times current power
    assign mul_next = {{(XW-SYM_BITS){1'b0}}, sym} * {{K{1'b0}}, power};

    // barrett quotient estimate
    assign quo_prod = {{QW{1'b0}}, mul_reg[XW-1:K-1]} * {{QW{1'b0}}, MU[QW-1:0]};
    assign quo_q    = quo_prod[2*QW-1:K+1];

    // remainder below three moduli, two corrections
    assign fold_qm = {1'b0, quo_q_reg} * MODULUS[RW-1:0];
    assign fold_r0 = quo_x_reg - fold_qm;
    assign fold_r1 = (fold_r0 >= MODULUS[RW-1:0]) ? fold_r0 - MODULUS[RW-1:0] : fold_r0;
    assign fold_r2 = (fold_r1 >= MODULUS[RW-1:0]) ? fold_r1 - MODULUS[RW-1:0] : fold_r1;

    assign sum_raw = {1'b0, acc_reg} + {1'b0, term_reg};
    assign sum_mod = (sum_raw >= MODULUS[K:0]) ? sum_raw - MODULUS[K:0] : sum_raw;

    always_ff @(posedge aclk) begin
        if (ctl.ld_mul) begin
            mul_reg <= mul_next;
        end
        if (ctl.ld_quo) begin
            quo_x_reg <= mul_reg[RW-1:0];
            quo_q_reg <= quo_q;
        end
        if (ctl.ld_fold) begin
            term_reg <= fold_r2[K-1:0];
        end
        if (ctl.commit) begin
            hash_reg <= sum_mod[K-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            acc_reg <= '0;
        end else if (ctl.commit) begin
            acc_reg <= sum_mod[K-1:0];
        end
    end

    assign hash = hash_reg;

endmodule

// ----- hw/rtl/triple_modulus_polynomial_hash_core.sv -----
// top level of the triple modulus polynomial rolling hash
`timescale 1ns / 1ps
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_symbol, s_last
//  m_      | out       | m_valid / m_ready  | m_hash_first, m_hash_second,
//          |           |                    | m_hash_third, m_done_res
//
// one transaction per cycle sustained while m_ready stays high; a result
// passes the product, quotient, fold and accumulate-and-output registers
// the power rings step on each accepted transaction, one power per unstalled cycle
// aresetn (synchronous) empties the pipeline, clears the accumulators and
// restarts the powers at one
// m_ready low holds the output; up to four transactions stay in flight and
// s_ready falls only when every stage is full
module triple_modulus_polynomial_hash_core #(
    parameter int SYMBOL_BITS = tmph_pkg::SYMBOL_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [tmph_pkg::SYMBOL_W-1:0]     s_symbol,
    input  logic                              s_last,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [tmph_pkg::HASH_A_BITS-1:0]  m_hash_first,
    output logic [tmph_pkg::HASH_B_BITS-1:0]  m_hash_second,
    output logic [tmph_pkg::HASH_C_BITS-1:0]  m_hash_third,
    output logic                              m_done_res
);
    import tmph_pkg::*;

    // symbol bits that take part in the hash
    localparam int SYM_USE = (SYMBOL_BITS < SYMBOL_W) ? SYMBOL_BITS : SYMBOL_W;

    // stage occupancy and the end-of-sequence flag riding along
    logic v_mul_reg, v_quo_reg, v_fold_reg, m_valid_reg;
    logic last_mul_reg, last_quo_reg, last_fold_reg, done_reg;

    logic en_mul, en_quo, en_fold, en_out;
    tmph_ctl_t ctl;

    logic [SYM_USE-1:0] sym_used;

    // a stage loads when it is empty or its content moves on
    assign en_out  = !m_valid_reg || m_ready;
    assign en_fold = !v_fold_reg || en_out;
    assign en_quo  = !v_quo_reg || en_fold;
    assign en_mul  = !v_mul_reg || en_quo;

    assign s_ready = en_mul;

    always_comb begin
        ctl.take    = s_valid && en_mul;
        ctl.restart = s_valid && en_mul && s_last;
        ctl.ld_mul  = en_mul;
        ctl.ld_quo  = en_quo;
        ctl.ld_fold = en_fold;
        ctl.commit  = en_out && v_fold_reg;
        ctl.clear   = en_out && v_fold_reg && last_fold_reg;
    end

    // valid bits of the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_mul_reg   <= 1'b0;
            v_quo_reg   <= 1'b0;
            v_fold_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en_mul) begin
                v_mul_reg <= s_valid;
            end
            if (en_quo) begin
                v_quo_reg <= v_mul_reg;
            end
            if (en_fold) begin
                v_fold_reg <= v_quo_reg;
            end
            if (en_out) begin
                m_valid_reg <= v_fold_reg;
            end
        end
    end

    // last flag follows its transaction down the pipe
    always_ff @(posedge aclk) begin
        if (en_mul) begin
            last_mul_reg <= s_last;
        end
        if (en_quo) begin
            last_quo_reg <= last_mul_reg;
        end
        if (en_fold) begin
            last_fold_reg <= last_quo_reg;
        end
        if (ctl.commit) begin
            done_reg <= last_fold_reg;
        end
    end

    assign sym_used = s_symbol[SYM_USE-1:0];

    // three independent lanes, one per modulus
    tmph_lane #(
        .HASH_BITS (HASH_A_BITS),
        .SYM_BITS  (SYM_USE),
        .MODULUS   (MOD_A),
        .MU        (MU_A),
        .STEP      (POW3_A),
        .SEED1     (POW1_A),
        .SEED2     (POW2_A)
    ) u_lane_first (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .sym     (sym_used),
        .hash    (m_hash_first)
    );

    tmph_lane #(
        .HASH_BITS (HASH_B_BITS),
        .SYM_BITS  (SYM_USE),
        .MODULUS   (MOD_B),
        .MU        (MU_B),
        .STEP      (POW3_B),
        .SEED1     (POW1_B),
        .SEED2     (POW2_B)
    ) u_lane_second (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .sym     (sym_used),
        .hash    (m_hash_second)
    );

    tmph_lane #(
        .HASH_BITS (HASH_C_BITS),
        .SYM_BITS  (SYM_USE),
        .MODULUS   (MOD_C),
        .MU        (MU_C),
        .STEP      (POW3_C),
        .SEED1     (POW1_C),
        .SEED2     (POW2_C)
    ) u_lane_third (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .sym     (sym_used),
        .hash    (m_hash_third)
    );

    assign m_valid    = m_valid_reg;
    assign m_done_res = done_reg;

endmodule

// ----- hw/rtl/tmph_checker.sv -----
// port level checks of the hash core and their bind
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tmph_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [tmph_pkg::HASH_A_BITS-1:0]  m_hash_first,
    input logic [tmph_pkg::HASH_B_BITS-1:0]  m_hash_second,
    input logic [tmph_pkg::HASH_C_BITS-1:0]  m_hash_third,
    input logic                              m_done_res
);
    import tmph_pkg::*;

    // reset empties the output
    `CHK_PROP_ALL(a_reset_empties, aclk, !aresetn |=> !m_valid, "output valid after reset")

    // every shown hash is fully reduced
    `CHK_PROP(a_hash_reduced, aclk, aresetn, m_valid |-> (m_hash_first < MOD_A) && (m_hash_second < MOD_B) && (m_hash_third < MOD_C), "hash not reduced")

    // a stalled result holds
    `CHK_PROP(a_result_holds, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_hash_first) && $stable(m_hash_second) && $stable(m_hash_third) && $stable(m_done_res), "stalled result changed")

    // a draining output never blocks the input
    `CHK_PROP(a_no_false_stall, aclk, aresetn, m_ready |-> s_ready, "input stalled while output drains")

endmodule

bind triple_modulus_polynomial_hash_core tmph_checker u_tmph_checker (.*);
